>>> src/mcalu_pkg.sv
// Types and constants shared by the minicomputer ALU files.
package mcalu_pkg;

	localparam int unsigned WORD_W    = 16;
	localparam int unsigned OFFSET_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] ROM_BASE_RST = 16'd49152;
	localparam logic [WORD_W-1:0] ROM_SIZE_RST = 16'd16384;

	localparam logic [WORD_W-1:0] WORD_MASK = 16'hFFFF;
	localparam logic [WORD_W-1:0] BYTE_MASK = 16'h00FF;
	localparam logic [WORD_W-1:0] WORD_SIGN = 16'h8000;
	localparam logic [WORD_W-1:0] BYTE_SIGN = 16'h0080;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROM_BASE = 2'd0,
		CFG_ROM_SIZE = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_CLR = 4'd0,
		OP_INC = 4'd1,
		OP_DEC = 4'd2,
		OP_NEG = 4'd3,
		OP_ADC = 4'd4,
		OP_SBC = 4'd5,
		OP_TST = 4'd6,
		OP_MOV = 4'd7,
		OP_CMP = 4'd8,
		OP_BIS = 4'd9,
		OP_ADD = 4'd10,
		OP_SUB = 4'd11,
		OP_BNE = 4'd12,
		OP_SOB = 4'd13
	} op_t;

	typedef struct packed {
		logic [3:0]          mode;
		logic                byte_op;
		logic [WORD_W-1:0]   src_value;
		logic [WORD_W-1:0]   dst_value;
		logic [WORD_W-1:0]   dst_address;
		logic [OFFSET_W-1:0] branch_offset;
		logic [WORD_W-1:0]   current_pc;
	} instr_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_value;
		logic              write_result;
		logic [WORD_W-1:0] next_pc;
		logic              flag_n;
		logic              flag_z;
		logic              flag_v;
		logic              flag_c;
		logic              halt_request;
	} result_t;

	typedef struct packed {
		logic n;
		logic z;
		logic v;
		logic c;
	} flags_t;

endpackage

>>> src/mcalu_in_if.sv
// Instruction channel: valid/ready handshake with a decoded instruction payload.
interface mcalu_in_if;
	logic                valid;
	logic                ready;
	mcalu_pkg::instr_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/mcalu_out_if.sv
// Result channel: valid/ready handshake with the write-back, branch and flag payload.
interface mcalu_out_if;
	logic                valid;
	logic                ready;
	mcalu_pkg::result_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/mcalu_exec.sv
// Single-pass execute logic: result, write enable, branch target and new flags.
module mcalu_exec (
	input  mcalu_pkg::instr_t                  item,
	input  mcalu_pkg::flags_t                  cur_flags,
	input  logic [mcalu_pkg::WORD_W-1:0]       rom_base,
	input  logic [mcalu_pkg::WORD_W-1:0]       rom_size,
	output mcalu_pkg::result_t                 res,
	output mcalu_pkg::flags_t                  nxt_flags,
	output logic                               flags_we
);

	logic                          bform;
	logic [mcalu_pkg::WORD_W-1:0]  wm;
	logic [mcalu_pkg::WORD_W-1:0]  sb;
	logic [mcalu_pkg::WORD_W-1:0]  s;
	logic [mcalu_pkg::WORD_W-1:0]  d;
	logic [mcalu_pkg::WORD_W:0]    rom_end;
	logic [mcalu_pkg::WORD_W:0]    sum;
	logic                          in_rom;
	logic [mcalu_pkg::WORD_W-1:0]  r;
	logic [mcalu_pkg::WORD_W-1:0]  npc;
	logic [mcalu_pkg::WORD_W-1:0]  boff;
	logic                          v;
	logic                          c;
	logic                          writes;
	logic                          guarded;
	logic                          flags;
	logic                          halt;

	assign bform   = item.byte_op && !item.mode[3];
	assign wm      = bform ? mcalu_pkg::BYTE_MASK : mcalu_pkg::WORD_MASK;
	assign sb      = bform ? mcalu_pkg::BYTE_SIGN : mcalu_pkg::WORD_SIGN;
	assign s       = item.src_value & wm;
	assign d       = item.dst_value & wm;
	// Window end is a 17-bit sum so a window reaching past the top does not wrap.
	assign rom_end = {1'b0, rom_base} + {1'b0, rom_size};
	assign in_rom  = (item.dst_address >= rom_base)
		&& ({1'b0, item.dst_address} < rom_end);
	assign sum     = {1'b0, s} + {1'b0, d};
	// Branch offset in bytes: twice the word count.
	assign boff    = {{(mcalu_pkg::WORD_W-mcalu_pkg::OFFSET_W-1){1'b0}},
		item.branch_offset, 1'b0};

	always_comb begin
		r       = '0;
		npc     = item.current_pc;
		v       = cur_flags.v;
		c       = cur_flags.c;
		writes  = 1'b0;
		guarded = 1'b0;
		flags   = 1'b1;
		halt    = 1'b0;
		case (mcalu_pkg::op_t'(item.mode))
			mcalu_pkg::OP_CLR: begin
				r = '0; v = 1'b0; c = 1'b0; writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_INC: begin
				r = (d + 16'd1) & wm; v = (d == sb - 16'd1);
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_DEC: begin
				r = (d - 16'd1) & wm; v = (d == sb);
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_NEG: begin
				r = (16'd0 - d) & wm; v = (r == sb); c = (r != '0);
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_ADC: begin
				r = (d + {15'd0, cur_flags.c}) & wm;
				v = cur_flags.c && (d == sb - 16'd1);
				c = cur_flags.c && (d == wm);
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_SBC: begin
				r = (d - {15'd0, cur_flags.c}) & wm;
				v = cur_flags.c && (d == sb);
				c = cur_flags.c && (d == '0);
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_TST: begin
				r = d; v = 1'b0; c = 1'b0;
			end
			mcalu_pkg::OP_MOV: begin
				r = s; v = 1'b0; writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_CMP: begin
				r = s - d;
				v = (((s ^ d) & (s ^ r) & sb) != '0);
				c = (s < d);
			end
			mcalu_pkg::OP_BIS: begin
				r = s | d; v = 1'b0; writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_ADD: begin
				r = sum[mcalu_pkg::WORD_W-1:0];
				v = ((~(s ^ d) & (s ^ r) & sb) != '0);
				c = sum[mcalu_pkg::WORD_W];
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_SUB: begin
				r = d - s;
				v = (((s ^ d) & (d ^ r) & sb) != '0);
				c = (d < s);
				writes = 1'b1; guarded = 1'b1;
			end
			mcalu_pkg::OP_BNE: begin
				flags = 1'b0;
				if (!cur_flags.z) begin
					// Sign-extend the doubled offset: subtract 512 when negative.
					npc = item.current_pc + boff
						- (item.branch_offset[mcalu_pkg::OFFSET_W-1] ? 16'd512 : 16'd0);
				end
			end
			mcalu_pkg::OP_SOB: begin
				flags  = 1'b0;
				r      = item.dst_value - 16'd1;
				writes = 1'b1;
				if (r != '0) begin
					npc = item.current_pc - boff;
				end
			end
			default: begin
				flags = 1'b0;
			end
		endcase

		if (guarded && in_rom) begin
			writes = 1'b0;
			flags  = 1'b0;
			halt   = (mcalu_pkg::op_t'(item.mode) == mcalu_pkg::OP_CLR);
		end
	end

	assign flags_we    = flags;
	assign nxt_flags.n = flags ? ((r & sb) != '0) : cur_flags.n;
	assign nxt_flags.z = flags ? (r == '0)        : cur_flags.z;
	assign nxt_flags.v = flags ? v                : cur_flags.v;
	assign nxt_flags.c = flags ? c                : cur_flags.c;

	assign res.result_value = writes ? r : '0;
	assign res.write_result = writes;
	assign res.next_pc      = npc;
	assign res.flag_n       = nxt_flags.n;
	assign res.flag_z       = nxt_flags.z;
	assign res.flag_v       = nxt_flags.v;
	assign res.flag_c       = nxt_flags.c;
	assign res.halt_request = halt;

endmodule

>>> src/minicomputer_alu_with_flags.sv
// An accepted instruction is executed from the input register into the result register.
// One instruction per cycle while results are taken; the flag register feeds the execute
// logic directly, so adc, sbc and bne see the flags left by the instruction just before.
// The result register frees the input side: a new beat is taken while a result waits.
// Reset (arst_n low): both stages empty, flags N Z V C cleared,
// ROM window back to base 0xC000 and size 0x4000.
module minicomputer_alu_with_flags (
	input  logic                                clk,
	input  logic                                arst_n,
	mcalu_in_if.sink                            instr,
	mcalu_out_if.source                         result,
	input  logic                                cfg_we,
	input  logic [mcalu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcalu_pkg::WORD_W-1:0]        cfg_data
);

	// Configuration registers.
	logic [mcalu_pkg::WORD_W-1:0] rom_base_q;
	logic [mcalu_pkg::WORD_W-1:0] rom_size_q;

	// Architectural flags.
	mcalu_pkg::flags_t flags_q;

	// Input register and result register.
	logic                 valid_s1;
	mcalu_pkg::instr_t    item_s1;
	logic                 valid_s2;
	mcalu_pkg::result_t   res_s2;

	// Execute outputs.
	mcalu_pkg::result_t   res_c;
	mcalu_pkg::flags_t    nxt_flags_c;
	logic                 flags_we_c;

	logic s2_free;
	logic adv_s1;
	logic take;

	// The result register can load when empty or when its beat leaves this cycle.
	assign s2_free     = !valid_s2 || result.ready;
	assign adv_s1      = valid_s1 && s2_free;
	// Take a new beat when the input register is empty or drains this cycle.
	assign instr.ready = !valid_s1 || s2_free;
	assign take        = instr.valid && instr.ready;

	// Write configuration; an index outside the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_base_q <= mcalu_pkg::ROM_BASE_RST;
			rom_size_q <= mcalu_pkg::ROM_SIZE_RST;
		end else if (cfg_we) begin
			case (mcalu_pkg::cfg_idx_t'(cfg_index))
				mcalu_pkg::CFG_ROM_BASE: rom_base_q <= cfg_data;
				mcalu_pkg::CFG_ROM_SIZE: rom_size_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mcalu_exec u_exec (
		.item      (item_s1),
		.cur_flags (flags_q),
		.rom_base  (rom_base_q),
		.rom_size  (rom_size_q),
		.res       (res_c),
		.nxt_flags (nxt_flags_c),
		.flags_we  (flags_we_c)
	);

	// Stage valids and flags: flags commit only as a flag-writing instruction moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end

			if (adv_s1 && flags_we_c) begin
				flags_q <= nxt_flags_c;
			end
		end
	end

	// Payload registers: load on advance, hold otherwise.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= instr.data;
		end
		if (adv_s1) begin
			res_s2 <= res_c;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	// A waiting result always carries the flags held in the flag register,
	// since no later instruction can commit flags until it leaves.
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.flag_n == flags_q.n && res_s2.flag_z == flags_q.z
			&& res_s2.flag_v == flags_q.v && res_s2.flag_c == flags_q.c))
		else $error("result flags differ from flag register");

	// Flags move only when an instruction advances out of the input register.
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(flags_q))
		else $error("flags changed without an advancing instruction");

	// A suppressed clear never writes back.
	a_halt_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.halt_request) |-> !res_s2.write_result)
		else $error("halt request together with a write");

	// An empty input register always takes a beat.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> instr.ready)
		else $error("input stalled while input register empty");

endmodule

>>> tb/tb_minicomputer_alu_with_flags.sv
`timescale 1ns / 100ps
// Self-checking bench for the minicomputer ALU: directed corners, then random instruction streams.
module tb_minicomputer_alu_with_flags;
	import mcalu_pkg::*;

	// Opcodes past the decoded set: the block must leave everything alone.
	localparam logic [3:0] OP_NONE_E = 4'd14;
	localparam logic [3:0] OP_NONE_F = 4'd15;
	// Register index with no register behind it; writes there are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned PHASE_BEATS     = 200;
	localparam int unsigned PHASES          = 7;

	// Flag-accurate shadow of the ALU plus the queue of result beats still owed.
	class alu_scoreboard;
		logic [WORD_W-1:0] rom_base;
		logic [WORD_W-1:0] rom_size;
		flags_t            ccr;
		result_t           results_due[$];
		int unsigned       errors;

		function void clear_state();
			rom_base = ROM_BASE_RST;
			rom_size = ROM_SIZE_RST;
			ccr      = '0;
			errors   = 0;
			results_due.delete();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
			if (idx == CFG_ROM_BASE)
				rom_base = val;
			else if (idx == CFG_ROM_SIZE)
				rom_size = val;
		endfunction

		// Execute one instruction against the shadow flags and queue its result beat.
		function void issue(instr_t x);
			logic              bform, in_rom, oc, v, c;
			logic              writes, guarded, upd, halt;
			logic [WORD_W-1:0] wm, sgn, s, d, r, npc;
			logic [WORD_W:0]   top, sum;
			result_t           e;

			bform  = x.byte_op && (x.mode <= OP_MOV);
			wm     = bform ? BYTE_MASK : WORD_MASK;
			sgn    = bform ? BYTE_SIGN : WORD_SIGN;
			s      = x.src_value & wm;
			d      = x.dst_value & wm;
			top    = {1'b0, rom_base} + {1'b0, rom_size};
			in_rom = (x.dst_address >= rom_base) && ({1'b0, x.dst_address} < top);

			r       = '0;
			npc     = x.current_pc;
			oc      = ccr.c;
			v       = ccr.v;
			c       = ccr.c;
			writes  = 1'b0;
			guarded = 1'b0;
			upd     = 1'b1;
			halt    = 1'b0;

			case (x.mode)
			OP_CLR: begin
				r = '0; v = 1'b0; c = 1'b0; writes = 1'b1; guarded = 1'b1;
			end
			OP_INC: begin
				r = (d + 16'd1) & wm; v = (d == sgn - 16'd1); writes = 1'b1; guarded = 1'b1;
			end
			OP_DEC: begin
				r = (d - 16'd1) & wm; v = (d == sgn); writes = 1'b1; guarded = 1'b1;
			end
			OP_NEG: begin
				r = (16'd0 - d) & wm; v = (r == sgn); c = (r != '0);
				writes = 1'b1; guarded = 1'b1;
			end
			OP_ADC: begin
				r = (d + {15'd0, oc}) & wm; v = oc && (d == sgn - 16'd1); c = oc && (d == wm);
				writes = 1'b1; guarded = 1'b1;
			end
			OP_SBC: begin
				r = (d - {15'd0, oc}) & wm; v = oc && (d == sgn); c = oc && (d == '0);
				writes = 1'b1; guarded = 1'b1;
			end
			OP_TST: begin
				r = d; v = 1'b0; c = 1'b0;
			end
			OP_MOV: begin
				r = s; v = 1'b0; writes = 1'b1; guarded = 1'b1;
			end
			OP_CMP: begin
				r = s - d; v = |((s ^ d) & (s ^ r) & sgn); c = (s < d);
			end
			OP_BIS: begin
				r = s | d; v = 1'b0; writes = 1'b1; guarded = 1'b1;
			end
			OP_ADD: begin
				sum = {1'b0, s} + {1'b0, d};
				r = sum[WORD_W-1:0]; v = |(~(s ^ d) & (s ^ r) & sgn); c = sum[WORD_W];
				writes = 1'b1; guarded = 1'b1;
			end
			OP_SUB: begin
				r = d - s; v = |((s ^ d) & (d ^ r) & sgn); c = (d < s);
				writes = 1'b1; guarded = 1'b1;
			end
			OP_BNE: begin
				upd = 1'b0;
				if (!ccr.z)
					npc = x.current_pc + {{7{x.branch_offset[7]}}, x.branch_offset, 1'b0};
			end
			OP_SOB: begin
				upd = 1'b0;
				r = x.dst_value - 16'd1;
				writes = 1'b1;
				if (r != '0)
					npc = x.current_pc - {7'd0, x.branch_offset, 1'b0};
			end
			default: begin
				upd = 1'b0;
			end
			endcase

			if (guarded && in_rom) begin
				writes = 1'b0;
				upd    = 1'b0;
				halt   = (x.mode == OP_CLR);
			end
			if (upd) begin
				ccr.n = |(r & sgn);
				ccr.z = (r == '0);
				ccr.v = v;
				ccr.c = c;
			end

			e.result_value = writes ? r : '0;
			e.write_result = writes;
			e.next_pc      = npc;
			e.flag_n       = ccr.n;
			e.flag_z       = ccr.z;
			e.flag_v       = ccr.v;
			e.flag_c       = ccr.c;
			e.halt_request = halt;
			results_due.push_back(e);
		endfunction

		function int unsigned field_diff(string name, logic [WORD_W-1:0] want,
				logic [WORD_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void retire(result_t got);
			result_t e;

			if (results_due.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, got);
				errors++;
				return;
			end
			e = results_due.pop_front();
			errors += field_diff("result_value", e.result_value, got.result_value);
			errors += field_diff("write_result", WORD_W'(e.write_result),
				WORD_W'(got.write_result));
			errors += field_diff("next_pc", e.next_pc, got.next_pc);
			errors += field_diff("flag_n", WORD_W'(e.flag_n), WORD_W'(got.flag_n));
			errors += field_diff("flag_z", WORD_W'(e.flag_z), WORD_W'(got.flag_z));
			errors += field_diff("flag_v", WORD_W'(e.flag_v), WORD_W'(got.flag_v));
			errors += field_diff("flag_c", WORD_W'(e.flag_c), WORD_W'(got.flag_c));
			errors += field_diff("halt_request", WORD_W'(e.halt_request),
				WORD_W'(got.halt_request));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	mcalu_in_if  instr_ch();
	mcalu_out_if result_ch();

	alu_scoreboard sb;
	bit            hold_req;   // ask the result side for one long hold-off
	bit            snd_burst;  // back-to-back stretch on the instruction side
	bit            rcv_burst;  // back-to-back stretch on the result side
	int unsigned   cycles;

	minicomputer_alu_with_flags DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.instr     (instr_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost beat ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic instr_t mk(logic [3:0] mode, logic bop, logic [WORD_W-1:0] src,
			logic [WORD_W-1:0] dst, logic [WORD_W-1:0] addr, logic [OFFSET_W-1:0] off,
			logic [WORD_W-1:0] pc);
		instr_t x;

		x.mode          = mode;
		x.byte_op       = bop;
		x.src_value     = src;
		x.dst_value     = dst;
		x.dst_address   = addr;
		x.branch_offset = off;
		x.current_pc    = pc;
		return x;
	endfunction

	// Bias operands toward the sign, carry and zero boundaries of both widths.
	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-1:0] w;

		w = WORD_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 11))
		0: w = 16'h0000;
		1: w = 16'h0001;
		2: w[7:0] = 8'h7F;
		3: w[7:0] = 8'h80;
		4: w[7:0] = 8'hFF;
		5: w = 16'h7FFF;
		6: w = 16'h8000;
		7: w = 16'hFFFF;
		8: w[7:0] = 8'h00;
		default: ;
		endcase
		return w;
	endfunction

	function automatic instr_t random_instr();
		instr_t          x;
		int unsigned     pick;
		logic [WORD_W:0] top;

		if ($urandom_range(0, 19) == 0)
			x.mode = 4'(OP_NONE_E + $urandom_range(0, 1));
		else
			x.mode = 4'($urandom_range(OP_CLR, OP_SOB));
		x.byte_op       = 1'($urandom_range(0, 1));
		x.src_value     = rand_word();
		x.dst_value     = rand_word();
		x.branch_offset = OFFSET_W'($urandom_range(0, 255));
		x.current_pc    = rand_word();

		// Aim a good share of destinations into the window and onto its edges.
		top = {1'b0, sb.rom_base} + {1'b0, sb.rom_size};
		if (top > 17'h10000)
			top = 17'h10000;
		pick = $urandom_range(0, 9);
		if (pick < 4 && sb.rom_size != 0)
			x.dst_address = WORD_W'($urandom_range(sb.rom_base, top - 1));
		else if (pick < 6)
			case ($urandom_range(0, 3))
			0: x.dst_address = sb.rom_base - 16'd1;
			1: x.dst_address = sb.rom_base;
			2: x.dst_address = top[WORD_W-1:0] - 16'd1;
			default: x.dst_address = top[WORD_W-1:0];
			endcase
		else
			x.dst_address = WORD_W'($urandom_range(0, 65535));
		return x;
	endfunction

	// Offer one instruction beat after a random gap; hold it until taken.
	task automatic send_instr(instr_t x);
		int unsigned gap;

		gap = snd_burst ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data  <= x;
		do @(posedge clk); while (!instr_ch.ready);
		sb.issue(x);
		if ($urandom_range(0, 29) == 0)
			snd_burst = !snd_burst;
	endtask

	// Drop valid and wait until every owed result beat has come back.
	task automatic drain();
		instr_ch.valid <= 1'b0;
		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Program the ROM window; optionally poke the unmapped index, which must be dropped.
	task automatic program_window(logic [WORD_W-1:0] base, logic [WORD_W-1:0] size,
			bit poke_spare);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROM_BASE;
		cfg_data  <= base;
		@(posedge clk);
		sb.write_reg(CFG_ROM_BASE, base);
		cfg_index <= CFG_ROM_SIZE;
		cfg_data  <= size;
		@(posedge clk);
		sb.write_reg(CFG_ROM_SIZE, size);
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data  <= ~base;
			@(posedge clk);
			sb.write_reg(CFG_SPARE, ~base);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: stall a random number of cycles per beat, or hold off long on request.
	initial begin : result_sink
		int unsigned stall;

		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else begin
				stall = rcv_burst ? 0 : $urandom_range(0, 16);
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.retire(result_ch.data);
			if ($urandom_range(0, 29) == 0)
				rcv_burst = !rcv_burst;
		end
	end

	initial begin : stimulus
		logic [WORD_W-1:0] base, size;

		sb = new();
		sb.clear_state();
		cycles          = 0;
		hold_req        = 1'b0;
		snd_burst       = 1'b0;
		rcv_burst       = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_ROM_BASE;
		cfg_data        = '0;
		instr_ch.valid  = 1'b0;
		instr_ch.data   = '0;
		result_ch.ready = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners under the reset window 0xC000..0xFFFF.
		send_instr(mk(OP_CLR, 1'b0, 16'h1234, 16'h5678, 16'h1000, 8'h00, 16'h0200));
		send_instr(mk(OP_CLR, 1'b1, 16'h1234, 16'h5678, 16'hC000, 8'h00, 16'h0202));
		send_instr(mk(OP_INC, 1'b0, 16'h0000, 16'h7FFF, 16'h0100, 8'h00, 16'h0204));
		send_instr(mk(OP_INC, 1'b1, 16'h0000, 16'hAB7F, 16'h0101, 8'h00, 16'h0206));
		send_instr(mk(OP_DEC, 1'b0, 16'h0000, 16'h8000, 16'hBFFF, 8'h00, 16'h0208));
		send_instr(mk(OP_NEG, 1'b0, 16'h0000, 16'h8000, 16'h0300, 8'h00, 16'h020A));
		send_instr(mk(OP_NEG, 1'b1, 16'h0000, 16'hFF00, 16'h0302, 8'h00, 16'h020C));
		send_instr(mk(OP_ADD, 1'b0, 16'hFFFF, 16'h0001, 16'h0400, 8'h00, 16'h020E));
		// Carry is set here, so the add-carry below rolls over.
		send_instr(mk(OP_ADC, 1'b0, 16'h0000, 16'hFFFF, 16'h0402, 8'h00, 16'h0210));
		send_instr(mk(OP_ADC, 1'b1, 16'h0000, 16'h007F, 16'h0404, 8'h00, 16'h0212));
		send_instr(mk(OP_SUB, 1'b0, 16'h0001, 16'h0000, 16'h0406, 8'h00, 16'h0214));
		send_instr(mk(OP_SBC, 1'b1, 16'h0000, 16'h3400, 16'h0408, 8'h00, 16'h0216));
		send_instr(mk(OP_ADD, 1'b0, 16'h7FFF, 16'h0001, 16'h040A, 8'h00, 16'h0218));
		send_instr(mk(OP_SUB, 1'b0, 16'h0001, 16'h8000, 16'h040C, 8'h00, 16'h021A));
		// Test reads from ROM freely; it is never write-guarded.
		send_instr(mk(OP_TST, 1'b1, 16'h0000, 16'hFF80, 16'hC000, 8'h00, 16'h021C));
		send_instr(mk(OP_CMP, 1'b0, 16'h8000, 16'h0001, 16'hFFFF, 8'h00, 16'h021E));
		send_instr(mk(OP_CMP, 1'b1, 16'h1234, 16'h1234, 16'h0000, 8'h00, 16'h0220));
		// Z is set: the branch falls through, and byte_op means nothing to it.
		send_instr(mk(OP_BNE, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h05, 16'h0400));
		// Bit set into the top ROM byte: no write and the flags hold.
		send_instr(mk(OP_BIS, 1'b0, 16'h00F0, 16'h0F00, 16'hFFFF, 8'h00, 16'h0222));
		send_instr(mk(OP_MOV, 1'b1, 16'h12FF, 16'h0000, 16'h2000, 8'h00, 16'h0224));
		// Z is clear now: taken branches wrapping backward and forward.
		send_instr(mk(OP_BNE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h80, 16'h0010));
		send_instr(mk(OP_BNE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h7F, 16'hFFF0));
		// Loop counter into ROM still writes; counter 1 ends the loop, 0 wraps.
		send_instr(mk(OP_SOB, 1'b0, 16'h0000, 16'h0001, 16'hC000, 8'h10, 16'h0300));
		send_instr(mk(OP_SOB, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 16'h0100));
		send_instr(mk(OP_NONE_E, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 16'hABCD));
		send_instr(mk(OP_NONE_F, 1'b1, 16'h0000, 16'h0000, 16'hC000, 8'h00, 16'h5432));

		// Pause the instruction side until everything is back before touching registers.
		drain();

		// Walk the window through empty, maximal, oversized and random shapes.
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: begin base = 16'h0000; size = 16'h0000; end
			1: begin base = 16'h0000; size = 16'h8000; end
			2: begin base = 16'hFFFF; size = 16'hFFFF; end
			3: begin base = 16'h0000; size = 16'hFFFF; end
			4: begin
				base = WORD_W'($urandom_range(0, 65535));
				size = WORD_W'($urandom_range(0, 32768));
			end
			5: begin base = 16'h8000; size = 16'h0001; end
			default: begin
				base = WORD_W'($urandom_range(0, 65535));
				size = WORD_W'($urandom_range(0, 65535));
			end
			endcase
			program_window(base, size, ph == 4);

			// Once, starve the result side so the block backs up into the instruction side.
			if (ph == 2)
				hold_req = 1'b1;
			repeat (PHASE_BEATS) send_instr(random_instr());
			drain();
		end

		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
